### src/motor_speed_pid_controller_defines.svh
// Assertion macros for the motor speed PID controller.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_PID_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSPID_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MSPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MSPID_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MSPID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/mspid_pkg.sv
`timescale 1ns / 1ps
package mspid_pkg;

	// input word action codes
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_CONTROL = 1'b1;

	// config register indexes
	localparam logic [2:0] REG_P_DIVISOR    = 3'd0;
	localparam logic [2:0] REG_I_GAIN       = 3'd1;
	localparam logic [2:0] REG_D_GAIN       = 3'd2;
	localparam logic [2:0] REG_SPEED_OFFSET = 3'd3;
	localparam logic [2:0] REG_SPEED_SCALE  = 3'd4;

	// reset values
	localparam logic [7:0] P_DIVISOR_RST    = 8'd5;
	localparam logic [7:0] I_GAIN_RST       = 8'd50;
	localparam logic [7:0] D_GAIN_RST       = 8'd50;
	localparam logic [7:0] SPEED_OFFSET_RST = 8'd28;
	localparam logic [7:0] SPEED_SCALE_RST  = 8'd9;
	localparam logic [7:0] DUTY_RST         = 8'd128;
	localparam logic [7:0] DUTY_MAX         = 8'd255;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPEED,
		ST_ERROR,
		ST_P_START,
		ST_P_WAIT,
		ST_I_ACC,
		ST_I_START,
		ST_I_WAIT,
		ST_D_START,
		ST_D_WAIT,
		ST_FINISH
	} mspid_state_t;

	typedef enum logic [1:0] {
		DIV_SRC_P,
		DIV_SRC_I,
		DIV_SRC_D
	} mspid_div_src_t;

	typedef struct packed {
		logic           sample;     // encoder pin sample
		logic           latch_req;  // capture set point
		logic           speed_mul;  // scale count, clear count
		logic           speed_err;  // clamp speed, form error
		logic           div_start;
		mspid_div_src_t div_src;
		logic           acc_add;    // add quotient into output sum
		logic           sum_add;    // error into running sum
		logic           d_update;   // store error for next derivative
		logic           finish;     // saturate, load output word
	} mspid_cmd_t;

	typedef struct packed {
		logic p_on;
		logic i_on;
		logic d_on;
		logic div_busy;
		logic div_done;
		logic out_busy;
	} mspid_status_t;

endpackage

### src/mspid_div.sv
`timescale 1ns / 1ps
module mspid_div #(
	parameter int SUM_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_BITS-1:0] dividend,
	input  logic [8:0]          divisor,
	output logic [SUM_BITS-1:0] quotient,
	output logic                busy,
	output logic                done
);
	import mspid_pkg::*;

	localparam int CNT_W = $clog2(SUM_BITS + 1);

	logic                busy_q;
	logic                fix_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [8:0]          rem_q;
	logic [8:0]          dvs_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [SUM_BITS-1:0] res_q;
	logic                neg_q;

	logic [9:0]          trial;
	logic [9:0]          trial_sub;
	logic                ge;
	logic [SUM_BITS-1:0] dvd_mag;

	// restoring division on magnitudes, sign fixed at the end (truncates to zero)
	assign trial     = {rem_q, quo_q[SUM_BITS-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = (trial >= {1'b0, dvs_q});
	assign dvd_mag   = dividend[SUM_BITS-1] ? ({SUM_BITS{1'b0}} - dividend) : dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dvd_mag;
			neg_q <= dividend[SUM_BITS-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[8:0] : trial[8:0];
			quo_q <= {quo_q[SUM_BITS-2:0], ge};
		end
		if (fix_q) begin
			res_q <= neg_q ? ({SUM_BITS{1'b0}} - quo_q) : quo_q;
		end
	end

	assign quotient = res_q;
	assign busy     = busy_q | fix_q;
	assign done     = done_q;

endmodule

### src/mspid_datapath.sv
`timescale 1ns / 1ps
module mspid_datapath #(
	parameter int SUM_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mspid_pkg::mspid_cmd_t   cmd,
	output mspid_pkg::mspid_status_t st,
	input  logic                    pin_level,
	input  logic [7:0]              required_speed,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [7:0]              pwm_duty,
	output logic [7:0]              measured_speed,
	output logic                    clamped
);
	import mspid_pkg::*;

	localparam int ACC_W = SUM_BITS + 2;
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(DUTY_MAX);

	// config registers
	logic [7:0] p_div_q, i_gain_q, d_gain_q, offset_q, scale_q;

	// controller state
	logic                       prev_pin_q;
	logic [7:0]                 count_q;
	logic [7:0]                 ctl_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic signed [8:0]          prev_err_q;

	// per-step working registers
	logic [7:0]              req_q;
	logic signed [17:0]      prod_q;
	logic signed [8:0]       error_q;
	logic signed [ACC_W-1:0] acc_q;

	// output word
	logic       out_valid_q;
	logic [7:0] duty_out_q, speed_out_q;
	logic       clamp_out_q;

	logic signed [8:0]          cnt_diff;
	logic signed [17:0]         prod;
	logic [7:0]                 speed_sat;
	logic signed [SUM_BITS-1:0] err_ext;
	logic signed [9:0]          d_diff;
	logic [SUM_BITS-1:0]        dvd;
	logic [8:0]                 dvs;
	logic [SUM_BITS-1:0]        quo;
	logic                       div_busy, div_done;
	logic [7:0]                 duty_next;
	logic                       clamp_next;

	assign cnt_diff = $signed({1'b0, count_q}) - $signed({1'b0, offset_q});
	assign prod     = 18'(cnt_diff) * 18'($signed({1'b0, scale_q}));
	assign err_ext  = {{(SUM_BITS-9){error_q[8]}}, error_q};
	assign d_diff   = {error_q[8], error_q} - {prev_err_q[8], prev_err_q};

	always_comb begin
		if (prod_q[17]) begin
			speed_sat = 8'd0;
		end else if (prod_q > 18'sd255) begin
			speed_sat = DUTY_MAX;
		end else begin
			speed_sat = prod_q[7:0];
		end
	end

	always_comb begin
		case (cmd.div_src)
			DIV_SRC_I: begin
				dvd = sum_q;
				dvs = {1'b0, i_gain_q} + 9'd1;
			end
			DIV_SRC_D: begin
				dvd = {{(SUM_BITS-10){d_diff[9]}}, d_diff};
				dvs = {1'b0, d_gain_q} + 9'd1;
			end
			default: begin
				dvd = err_ext;
				dvs = {1'b0, p_div_q};
			end
		endcase
	end

	mspid_div #(
		.SUM_BITS(SUM_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dvd),
		.divisor (dvs),
		.quotient(quo),
		.busy    (div_busy),
		.done    (div_done)
	);

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			duty_next  = 8'd0;
			clamp_next = 1'b1;
		end else if (acc_q > ACC_MAX) begin
			duty_next  = DUTY_MAX;
			clamp_next = 1'b1;
		end else begin
			duty_next  = acc_q[7:0];
			clamp_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_div_q     <= P_DIVISOR_RST;
			i_gain_q    <= I_GAIN_RST;
			d_gain_q    <= D_GAIN_RST;
			offset_q    <= SPEED_OFFSET_RST;
			scale_q     <= SPEED_SCALE_RST;
			prev_pin_q  <= 1'b0;
			count_q     <= '0;
			ctl_q       <= DUTY_RST;
			sum_q       <= '0;
			prev_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_P_DIVISOR:    p_div_q  <= cfg_data;
					REG_I_GAIN:       i_gain_q <= cfg_data;
					REG_D_GAIN:       d_gain_q <= cfg_data;
					REG_SPEED_OFFSET: offset_q <= cfg_data;
					REG_SPEED_SCALE:  scale_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.sample) begin
				if (!prev_pin_q && pin_level) begin
					count_q <= count_q + 8'd1;
				end
				prev_pin_q <= pin_level;
			end
			if (cmd.speed_mul) begin
				count_q <= '0;
			end
			if (cmd.sum_add) begin
				sum_q <= sum_q + err_ext;
			end
			if (cmd.d_update) begin
				prev_err_q <= error_q;
			end
			if (cmd.finish) begin
				ctl_q       <= duty_next;
				out_valid_q <= 1'b1;
				// anti-windup: back the error out of the sum
				if (clamp_next) begin
					sum_q <= sum_q - err_ext;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= required_speed;
		end
		if (cmd.speed_mul) begin
			prod_q <= prod;
		end
		if (cmd.speed_err) begin
			error_q <= $signed({1'b0, req_q}) - $signed({1'b0, speed_sat});
			acc_q   <= ACC_W'(ctl_q);
		end
		if (cmd.acc_add) begin
			acc_q <= acc_q + {{2{quo[SUM_BITS-1]}}, quo};
		end
		if (cmd.finish) begin
			duty_out_q  <= duty_next;
			speed_out_q <= speed_sat;
			clamp_out_q <= clamp_next;
		end
	end

	assign st.p_on     = (p_div_q != 8'd0);
	assign st.i_on     = (i_gain_q != 8'd0);
	assign st.d_on     = (d_gain_q != 8'd0);
	assign st.div_busy = div_busy;
	assign st.div_done = div_done;
	assign st.out_busy = out_valid_q & out_stall;

	assign out_valid      = out_valid_q;
	assign pwm_duty       = duty_out_q;
	assign measured_speed = speed_out_q;
	assign clamped        = clamp_out_q;

endmodule

### src/mspid_ctrl.sv
`timescale 1ns / 1ps
module mspid_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  mspid_pkg::mspid_status_t st,
	output mspid_pkg::mspid_cmd_t    cmd
);
	import mspid_pkg::*;

	mspid_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && action == ACT_CONTROL) begin
					state_next = ST_SPEED;
				end
			end
			ST_SPEED:   state_next = ST_ERROR;
			ST_ERROR:   state_next = ST_P_START;
			ST_P_START: state_next = st.p_on ? ST_P_WAIT : ST_I_ACC;
			ST_P_WAIT: begin
				if (st.div_done) begin
					state_next = ST_I_ACC;
				end
			end
			ST_I_ACC:   state_next = st.i_on ? ST_I_START : ST_D_START;
			ST_I_START: state_next = ST_I_WAIT;
			ST_I_WAIT: begin
				if (st.div_done) begin
					state_next = ST_D_START;
				end
			end
			ST_D_START: state_next = st.d_on ? ST_D_WAIT : ST_FINISH;
			ST_D_WAIT: begin
				if (st.div_done) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!st.out_busy) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.div_src = DIV_SRC_P;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.sample    = (action == ACT_SAMPLE);
					cmd.latch_req = (action == ACT_CONTROL);
				end
			end
			ST_SPEED: cmd.speed_mul = 1'b1;
			ST_ERROR: cmd.speed_err = 1'b1;
			ST_P_START: begin
				cmd.div_start = st.p_on;
				cmd.div_src   = DIV_SRC_P;
			end
			ST_P_WAIT: cmd.acc_add = st.div_done;
			ST_I_ACC:  cmd.sum_add = st.i_on;
			ST_I_START: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_SRC_I;
			end
			ST_I_WAIT: cmd.acc_add = st.div_done;
			ST_D_START: begin
				cmd.div_start = st.d_on;
				cmd.div_src   = DIV_SRC_D;
			end
			ST_D_WAIT: begin
				cmd.acc_add  = st.div_done;
				cmd.d_update = st.div_done;
			end
			ST_FINISH: cmd.finish = !st.out_busy;
			default: ;
		endcase
	end

endmodule

### src/motor_speed_pid_controller.sv
`timescale 1ns / 1ps
// Motor speed PID controller with anti-windup. Input words either sample the
// encoder pin (action 0: a rising pin level bumps an 8-bit wrapping pulse
// count, no output word) or run one control step (action 1: the count becomes
// measured_speed = speed_scale*(count-speed_offset) clamped to 0..255, the
// count clears, and the duty moves by error/p_divisor, error_sum/(i_gain+1)
// and (error-previous_error)/(d_gain+1), each truncated toward zero; a zero
// gain skips its term). The duty saturates to 0..255, and on saturation the
// error is removed from the SUM_BITS wide wrapping error sum and clamped is
// set. A control step runs its divisions on one shared radix-2 divider that
// serves all three in turn; a disabled term skips its division. No new
// input word is taken until the step is done. The final step also waits
// while an earlier word is stalled in the output register. A finished word
// sits in the output register while the next words are taken in. Config
// registers (index 0..4: p_divisor, i_gain, d_gain, speed_offset,
// speed_scale) are always ready and are meant to be written while idle.
`include "motor_speed_pid_controller_defines.svh"
module motor_speed_pid_controller #(
	parameter int SUM_BITS = 16    // error sum width, 16..32
) (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic       pin_level,
	input  logic [7:0] required_speed,
	// output words
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pwm_duty,
	output logic [7:0] measured_speed,
	output logic       clamped,
	// config writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import mspid_pkg::*;

	mspid_cmd_t    cmd;
	mspid_status_t st;

	// config path has no backpressure
	assign cfg_ready = 1'b1;

	// sequencer: walks speed, P, I, D and saturation steps
	mspid_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action  (action),
		.st      (st),
		.cmd     (cmd)
	);

	// registers, speed multiplier, divider and output word
	mspid_datapath #(
		.SUM_BITS(SUM_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.pin_level     (pin_level),
		.required_speed(required_speed),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.pwm_duty      (pwm_duty),
		.measured_speed(measured_speed),
		.clamped       (clamped)
	);

	// a clamped word always sits on a rail
	`MSPID_ASSERT_IMPLY(a_clamp_rail, out_valid && clamped, pwm_duty == 8'd0 || pwm_duty == 8'd255, "clamped duty off rail")
	// divider is only started when free
	`MSPID_ASSERT_IMPLY(a_div_free, cmd.div_start, !st.div_busy && !st.div_done, "divider restarted while busy")
	// finishing a step always presents a word next cycle
	`MSPID_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid, "finished step lost its output word")

endmodule

### sim/tb_motor_speed_pid_controller.sv
`timescale 1ns / 1ps
module tb_motor_speed_pid_controller;
	import mspid_pkg::*;

	// Error sum width. The predictor and the DUT must agree on it.
	localparam int SUM_W = 16;
	// Idle settle time after the last result, long enough to cover any word
	// still in flight.
	localparam int SETTLE = 100;
	// Run guard limit; the slowest legal run leaves it a wide margin.
	localparam int CYCLE_LIMIT = 400000;

	// One expected output word.
	typedef struct {
		logic [7:0] duty;
		logic [7:0] speed;
		logic       clamp;
	} duty_word_t;

	// Tracks gains, encoder count and controller state, and holds the output
	// words that accepted control steps should produce, oldest first.
	class duty_predictor;
		bit [7:0]              p_div  = P_DIVISOR_RST;
		bit [7:0]              i_gain = I_GAIN_RST;
		bit [7:0]              d_gain = D_GAIN_RST;
		bit [7:0]              offset = SPEED_OFFSET_RST;
		bit [7:0]              scale  = SPEED_SCALE_RST;
		bit                    prev_pin;
		bit [7:0]              pulses;
		bit [7:0]              duty = DUTY_RST;
		bit signed [SUM_W-1:0] err_sum;
		int                    prev_err;
		duty_word_t            pending[$];
		int                    mismatches;
		int                    results;

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
			REG_P_DIVISOR:    p_div  = val;
			REG_I_GAIN:       i_gain = val;
			REG_D_GAIN:       d_gain = val;
			REG_SPEED_OFFSET: offset = val;
			REG_SPEED_SCALE:  scale  = val;
			default: ;
			endcase
		endfunction

		// Note one accepted input word; a control step queues one output word.
		function void take_word(logic act, logic pin, logic [7:0] req);
			int         spd;
			int         err;
			int         ctl;
			duty_word_t w;
			if (act == ACT_SAMPLE) begin
				if (!prev_pin && pin)
					pulses++;
				prev_pin = pin;
				return;
			end
			spd = int'(scale) * (int'(pulses) - int'(offset));
			if (spd < 0)
				spd = 0;
			if (spd > 255)
				spd = 255;
			pulses = '0;
			err = int'(req) - spd;
			ctl = int'(duty);
			// zero divisor: proportional term skipped
			if (p_div != 0)
				ctl += err / int'(p_div);
			if (i_gain != 0) begin
				err_sum += err;
				ctl += int'(err_sum) / (int'(i_gain) + 1);
			end
			// old error kept only while the derivative term is on
			if (d_gain != 0) begin
				ctl += (err - prev_err) / (int'(d_gain) + 1);
				prev_err = err;
			end
			// anti-windup runs even with the integral term off
			w.clamp = 1'b0;
			if (ctl > 255) begin
				ctl = 255;
				err_sum -= err;
				w.clamp = 1'b1;
			end else if (ctl < 0) begin
				ctl = 0;
				err_sum -= err;
				w.clamp = 1'b1;
			end
			duty = ctl[7:0];
			w.duty = duty;
			w.speed = spd[7:0];
			pending.push_back(w);
			results++;
		endfunction

		function void flag(string what, int exp_v, int got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		endfunction

		function void match_word(logic [7:0] duty_o, logic [7:0] speed_o, logic clamp_o);
			duty_word_t w;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: output word with nothing pending, pwm_duty %0d", $time, duty_o);
				return;
			end
			w = pending.pop_front();
			if (duty_o !== w.duty)
				flag("pwm_duty", w.duty, duty_o);
			if (speed_o !== w.speed)
				flag("measured_speed", w.speed, speed_o);
			if (clamp_o !== w.clamp)
				flag("clamped", w.clamp, clamp_o);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       action;
	logic       pin_level;
	logic [7:0] required_speed;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pwm_duty;
	logic [7:0] measured_speed;
	logic       clamped;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	duty_predictor model = new();
	int            words_sent;
	int            cycles;
	bit            steady;     // high: neither side idles

	motor_speed_pid_controller #(
		.SUM_BITS(SUM_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.pin_level     (pin_level),
		.required_speed(required_speed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pwm_duty      (pwm_duty),
		.measured_speed(measured_speed),
		.clamped       (clamped),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("motor_speed_pid_controller verification failed");
			$finish;
		end
	end

	// Receiver backpressure: roughly 28% stalled, none during the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 28);
	end

	// Both handshakes are sampled here, in the active region of the edge, so
	// every value read is the one from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0)
				model.take_word(action, pin_level, required_speed);
			if (out_valid === 1'b1 && !out_stall)
				model.match_word(pwm_duty, measured_speed, clamped);
		end
	end

	// Present one input word, after an optional idle gap, and hold it until
	// taken. Valid is left high on return; the next call or a drain lowers it,
	// so valid never sees two assignments in one step.
	task automatic push_word(logic act, logic pin, logic [7:0] req);
		int gap;
		gap = (!steady && $urandom_range(99) < 28) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pin_level <= pin;
		required_speed <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		words_sent++;
	endtask

	// Sample word; the unused set point carries random bits.
	task automatic sample(logic pin);
		push_word(ACT_SAMPLE, pin, 8'($urandom));
	endtask

	// Control step; the unused pin bit is random.
	task automatic control(logic [7:0] req);
		push_word(ACT_CONTROL, 1'($urandom), req);
	endtask

	// n clean encoder pulses, low then high.
	task automatic pulse_train(int n);
		repeat (n) begin
			sample(1'b0);
			sample(1'b1);
		end
	endtask

	// Hold the input side off until every expected word is back, plus the
	// settle time for words that produce no output.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		model.write_reg(idx, val);
	endtask

	// Full gain set, plus one write to an unused index that must be ignored.
	task automatic load_gains(logic [7:0] p, logic [7:0] ig, logic [7:0] dg,
			logic [7:0] off, logic [7:0] sc);
		cfg_write(REG_P_DIVISOR, p);
		cfg_write(REG_I_GAIN, ig);
		cfg_write(REG_D_GAIN, dg);
		cfg_write(REG_SPEED_OFFSET, off);
		cfg_write(REG_SPEED_SCALE, sc);
		cfg_write(3'(REG_SPEED_SCALE + $urandom_range(1, 3)), 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// One control period: pulses mostly aimed at the useful speed band for
	// the current offset and scale, some near-empty or off-band counts, now
	// and then stray pin samples, then a control step.
	task automatic random_round();
		int         n;
		int         span;
		int         r;
		logic [7:0] req;
		span = (model.scale == 0) ? 4 : 255 / model.scale + 1;
		r = $urandom_range(99);
		if (r < 30)
			n = $urandom_range(0, 3);
		else if (r < 80)
			n = model.offset + $urandom_range(0, span);
		else
			n = $urandom_range(0, 40);
		if (n > 64)
			n = 64;
		pulse_train(n);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 6)) sample(1'($urandom));
		r = $urandom_range(99);
		if (r < 10)
			req = 8'd0;
		else if (r < 20)
			req = DUTY_MAX;
		else
			req = 8'($urandom);
		control(req);
	endtask

	task automatic run_phase(int words);
		int target;
		target = words_sent + words;
		while (words_sent < target)
			random_round();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_SAMPLE;
		pin_level <= 1'b0;
		required_speed <= 8'd0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_P_DIVISOR;
		cfg_data <= 8'd0;
		steady = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gains: empty count, full-scale set point, a held-high pin
		// (second high is no edge), then a small count.
		control(8'd0);
		control(DUTY_MAX);
		sample(1'b1);
		sample(1'b1);
		sample(1'b0);
		sample(1'b1);
		control(8'd128);
		control(8'd0);
		run_phase(100);
		drain();

		// Unit P divisor, I and D off, full scale: one pulse reads as max
		// speed, so the duty pins low; clamp with integral off still unwinds
		// the sum. Then drive to exactly 255 and past it.
		load_gains(8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
		sample(1'b0);
		sample(1'b1);
		control(8'd0);
		control(DUTY_MAX);
		control(DUTY_MAX);
		pulse_train(2);
		control(DUTY_MAX);
		run_phase(80);
		drain();

		// Zero P divisor (term skipped), widest I and D divisors, zero scale.
		load_gains(8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
		control(8'd200);
		control(8'd0);
		control(DUTY_MAX);
		run_phase(60);
		drain();

		// Long stretch with no idling on either side.
		load_gains(8'd3, 8'd7, 8'd2, 8'd4, 8'd20);
		steady = 1'b1;
		run_phase(150);
		steady = 1'b0;
		run_phase(60);
		drain();

		load_gains(8'd255, 8'd1, 8'd0, 8'd10, 8'd5);
		run_phase(100);
		drain();

		load_gains(8'd2, 8'd0, 8'd9, 8'd0, 8'd1);
		run_phase(80);
		drain();

		// Count wrap: 260 pulses leave the 8-bit count at 4.
		load_gains(8'd7, 8'd15, 8'd31, 8'd2, 8'd30);
		pulse_train(260);
		control(8'd90);
		while (model.results < 60)
			random_round();
		run_phase(40);
		drain();

		if (model.mismatches == 0 && model.pending.size() == 0)
			$display("motor_speed_pid_controller verification clean");
		else
			$display("motor_speed_pid_controller verification failed");
		$finish;
	end

endmodule
